>>> sv/mru_pkg.sv
// Package for the MRU frame table: sizes, widths and the cell chain word.
// No dependencies; used by mru_cell and mru_page_replacement.
`default_nettype none
package mru_pkg;

    localparam int FRAMES    = 4;
    localparam int PAGE_BITS = 8;
    localparam int CNT_W     = 32;
    localparam int CFG_W     = 3;
    localparam int SLOT_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FILL_W    = $clog2(FRAMES + 1);
    localparam int CAP_W     = (FILL_W > CFG_W) ? FILL_W : CFG_W;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

    // Match word handed from cell to cell: first matching slot wins.
    typedef struct packed {
        logic                 hit;
        logic [SLOT_BITS-1:0] slot;
    } mru_chain_t;

endpackage
`default_nettype wire

>>> sv/mru_cell.sv
// One frame of the table: holds a page tag and its valid bit, compares it
// against the referenced page and passes the match word on. Uses mru_pkg.
`default_nettype none
module mru_cell
    import mru_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [SLOT_BITS-1:0] idx,
    input  wire logic [PAGE_BITS-1:0] page,
    input  wire logic                 wr,
    input  wire mru_chain_t           chain_in,
    output mru_chain_t                chain_out,
    output logic [PAGE_BITS-1:0]      tag
);

    logic [PAGE_BITS-1:0] tag_reg;
    logic                 valid_reg;
    logic                 match;

    assign match = valid_reg && (tag_reg == page);

    always_comb
    begin
        chain_out = chain_in;
        // claim the match only if no earlier frame already did
        if (!chain_in.hit && match)
        begin
            chain_out.hit  = 1'b1;
            chain_out.slot = idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            tag_reg <= page;
        end
    end

    assign tag = tag_reg;

endmodule
`default_nettype wire

>>> sv/mru_page_replacement.sv
// Top level of the MRU frame table: a chain of mru_cell frames plus the
// fill, replacement and counter logic. Uses mru_pkg and mru_cell.
//
// Usage:
//   Drive page and pulse start while busy is low; the reference is taken at
//   that clock edge. In the next cycle done pulses for one cycle with hit,
//   evicted, evicted_page, hit_total and fault_total. busy stays low, so a
//   reference may be given every cycle: one reference per cycle. The tag
//   compare ripples through the row of frame cells within the accepting
//   cycle.
//   The frame count is written on the cfg channel (cfg_valid/cfg_ready,
//   cfg_data) while no reference is in flight; cfg_ready is always high.
//   Zero acts as one frame, values above the table size as the full table.
//   Reset empties every frame, clears both totals and the last-used slot,
//   and sets the frame count to four.
//   The receiver cannot stall: each result word is shown for exactly one
//   cycle and must be taken then.
//   Totals saturate at their maximum.
`default_nettype none
module mru_page_replacement
    import mru_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [PAGE_BITS-1:0] page,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output logic                      done,
    output logic                      hit,
    output logic                      evicted,
    output logic [PAGE_BITS-1:0]      evicted_page,
    output logic [CNT_W-1:0]          hit_total,
    output logic [CNT_W-1:0]          fault_total
);

    logic [CFG_W-1:0]     cfg_reg;
    logic [SLOT_BITS-1:0] last_reg, last_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [CNT_W-1:0]     hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]     fault_cnt_reg, fault_cnt_next;
    logic                 done_reg;
    logic                 hit_reg, hit_next;
    logic                 evict_reg, evict_next;
    logic [PAGE_BITS-1:0] evpage_reg, evpage_next;

    mru_chain_t           chain [FRAMES+1];
    logic [PAGE_BITS-1:0] tags  [FRAMES];
    logic [FRAMES-1:0]    wr;

    logic                 accept;
    logic [CAP_W-1:0]     cap;
    logic                 has_free;
    logic [SLOT_BITS-1:0] new_slot;

    assign accept    = start && !busy;
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    assign chain[0] = '0;

    for (genvar i = 0; i < FRAMES; i++)
    begin : g_cell
        assign wr[i] = accept && !chain[FRAMES].hit && (new_slot == SLOT_BITS'(i));

        mru_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (SLOT_BITS'(i)),
            .page      (page),
            .wr        (wr[i]),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .tag       (tags[i])
        );
    end

    // clamp the configured frame count into one..FRAMES
    always_comb
    begin
        priority if (cfg_reg == '0)
        begin
            cap = CAP_W'(1);
        end
        else if (CAP_W'(cfg_reg) > CAP_W'(FRAMES))
        begin
            cap = CAP_W'(FRAMES);
        end
        else
        begin
            cap = CAP_W'(cfg_reg);
        end
    end

    assign has_free = CAP_W'(fill_reg) < cap;
    assign new_slot = has_free ? fill_reg[SLOT_BITS-1:0] : last_reg;

    always_comb
    begin
        last_next      = last_reg;
        fill_next      = fill_reg;
        hit_cnt_next   = hit_cnt_reg;
        fault_cnt_next = fault_cnt_reg;
        hit_next       = 1'b0;
        evict_next     = 1'b0;
        evpage_next    = '0;
        if (accept)
        begin
            if (chain[FRAMES].hit)
            begin
                hit_next     = 1'b1;
                last_next    = chain[FRAMES].slot;
                hit_cnt_next = (hit_cnt_reg == CNT_MAX) ? CNT_MAX : hit_cnt_reg + 1'b1;
            end
            else
            begin
                fault_cnt_next = (fault_cnt_reg == CNT_MAX) ? CNT_MAX
                                                            : fault_cnt_reg + 1'b1;
                last_next      = new_slot;
                if (has_free)
                begin
                    fill_next = fill_reg + 1'b1;
                end
                else
                begin
                    // frame limit reached: drop the most recent page
                    evict_next  = 1'b1;
                    evpage_next = tags[last_reg];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_RESET;
            last_reg      <= '0;
            fill_reg      <= '0;
            hit_cnt_reg   <= '0;
            fault_cnt_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end
            last_reg      <= last_next;
            fill_reg      <= fill_next;
            hit_cnt_reg   <= hit_cnt_next;
            fault_cnt_reg <= fault_cnt_next;
            done_reg      <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg    <= hit_next;
            evict_reg  <= evict_next;
            evpage_reg <= evpage_next;
        end
    end

    assign done         = done_reg;
    assign hit          = hit_reg;
    assign evicted      = evict_reg;
    assign evicted_page = evpage_reg;
    assign hit_total    = hit_cnt_reg;
    assign fault_total  = fault_cnt_reg;

endmodule
`default_nettype wire

>>> tb/mru_checker.sv
`timescale 1ns / 1ps
// Checker for the MRU frame table: watches the reference, cfg and result ports,
// predicts each result word and compares it field by field. Uses mru_pkg.
module mru_checker
    import mru_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic [PAGE_BITS-1:0] page,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 done,
    input  wire logic                 hit,
    input  wire logic                 evicted,
    input  wire logic [PAGE_BITS-1:0] evicted_page,
    input  wire logic [CNT_W-1:0]     hit_total,
    input  wire logic [CNT_W-1:0]     fault_total,
    output int                        fail_count,
    output int                        outstanding
);

    typedef struct packed {
        logic                 hit;
        logic                 evicted;
        logic [PAGE_BITS-1:0] evicted_page;
        logic [CNT_W-1:0]     hit_total;
        logic [CNT_W-1:0]     fault_total;
    } frame_result_t;

    frame_result_t        pending_q[$];

    // Own copy of the frame table
    logic [PAGE_BITS-1:0] tag_mem   [FRAMES];
    logic                 valid_mem [FRAMES];
    int                   mru_slot;
    int                   fill_cnt;
    logic [CNT_W-1:0]     hits;
    logic [CNT_W-1:0]     faults;
    logic [CFG_W-1:0]     frame_limit;

    function automatic frame_result_t reference_page(input logic [PAGE_BITS-1:0] p);
        frame_result_t r;
        int            slot;
        int            cap;
        bit            found;
        r     = '0;
        slot  = 0;
        found = 1'b0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (!found && valid_mem[i] && tag_mem[i] == p)
            begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found)
        begin
            r.hit    = 1'b1;
            mru_slot = slot;
            if (hits != CNT_MAX)
                hits = hits + 1'b1;
        end
        else
        begin
            if (faults != CNT_MAX)
                faults = faults + 1'b1;
            // Zero acts as one frame, anything above the table as the full table
            cap = int'(frame_limit);
            if (cap < 1)
                cap = 1;
            if (cap > FRAMES)
                cap = FRAMES;
            if (fill_cnt < cap && fill_cnt < FRAMES)
            begin
                slot     = fill_cnt;
                fill_cnt = fill_cnt + 1;
            end
            else
            begin
                slot           = mru_slot;
                r.evicted      = 1'b1;
                r.evicted_page = tag_mem[slot];
            end
            tag_mem[slot]   = p;
            valid_mem[slot] = 1'b1;
            mru_slot        = slot;
        end
        r.hit_total   = hits;
        r.fault_total = faults;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t want;
        if (!rst_n)
        begin
            pending_q.delete();
            for (int i = 0; i < FRAMES; i++)
            begin
                tag_mem[i]   = '0;
                valid_mem[i] = 1'b0;
            end
            mru_slot    = 0;
            fill_cnt    = 0;
            hits        = '0;
            faults      = '0;
            frame_limit = CFG_RESET;
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            // Compare the word of the previous reference before taking a new one
            if (done)
            begin
                if (pending_q.size() == 0)
                begin
                    $display("%0t: result word with nothing expected: expected none, actual %0h",
                             $time, {hit, evicted, evicted_page, hit_total, fault_total});
                    fail_count++;
                end
                else
                begin
                    want = pending_q.pop_front();
                    check_field("hit", want.hit, hit);
                    check_field("evicted", want.evicted, evicted);
                    check_field("evicted_page", want.evicted_page, evicted_page);
                    check_field("hit_total", want.hit_total, hit_total);
                    check_field("fault_total", want.fault_total, fault_total);
                end
            end
            if (cfg_valid && cfg_ready)
                frame_limit = cfg_data;
            if (start && !busy)
                pending_q.push_back(reference_page(page));
            outstanding = pending_q.size();
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the MRU frame table testbench: clock, reset, page references and
// frame count writes; mru_checker does the prediction. Uses mru_pkg.
module tb_top;
    import mru_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [PAGE_BITS-1:0] page;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;
    logic                 done;
    logic                 hit;
    logic                 evicted;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     fault_total;
    int                   fail_count;
    int                   outstanding;

    bit                   no_idle;
    logic [PAGE_BITS-1:0] last_page;

    mru_page_replacement i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .page         (page),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .done         (done),
        .hit          (hit),
        .evicted      (evicted),
        .evicted_page (evicted_page),
        .hit_total    (hit_total),
        .fault_total  (fault_total)
    );

    mru_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .page         (page),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .done         (done),
        .hit          (hit),
        .evicted      (evicted),
        .evicted_page (evicted_page),
        .hit_total    (hit_total),
        .fault_total  (fault_total),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hold start for the next word; it is not dropped between back-to-back words
    task automatic send_page(input logic [PAGE_BITS-1:0] p);
        @(negedge clk);
        start <= 1'b1;
        page  <= p;
        last_page = p;
        do @(posedge clk); while (busy);
    endtask

    task automatic idle_cycle();
        @(negedge clk);
        start <= 1'b0;
        page  <= PAGE_BITS'($urandom);
    endtask

    task automatic random_gap();
        if (!no_idle)
            while ($urandom_range(0, 99) < 18)
                idle_cycle();
    endtask

    // Drain every expected word, then let the pipeline settle
    task automatic drain();
        idle_cycle();
        while (outstanding != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data  <= CFG_W'($urandom);
    endtask

    initial
    begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        logic [CFG_W-1:0]     limits [8];
        logic [PAGE_BITS-1:0] base;
        int                   pool;
        int                   pick;
        limits    = '{3'd5, 3'd2, 3'd6, 3'd4, 3'd0, 3'd3, 3'd7, 3'd1};
        rst_n     = 1'b0;
        start     = 1'b0;
        page      = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        no_idle   = 1'b0;
        last_page = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset frame count first, then lower, raise, zero, oversize and back to four
        send_page(8'h00);
        send_page(8'hFF);
        send_page(8'h00);
        send_page(8'hFF);
        write_frames(3'd1);
        send_page(8'h07);
        send_page(8'h00);
        send_page(8'h09);
        write_frames(3'd3);
        send_page(8'hAA);
        send_page(8'h55);
        send_page(8'h00);
        write_frames(3'd0);
        send_page(8'h01);
        send_page(8'h80);
        send_page(8'h01);
        write_frames(3'd7);
        send_page(8'hF0);
        send_page(8'h0F);
        send_page(8'h0F);
        send_page(8'hFE);
        write_frames(3'd4);
        send_page(8'h5A);
        send_page(8'hA5);
        send_page(8'h5A);

        // Random phases with a small working set so hits and evictions both occur
        for (int ph = 0; ph < 8; ph++)
        begin
            write_frames(limits[ph]);
            no_idle = (ph == 2);
            base    = PAGE_BITS'($urandom);
            pool    = $urandom_range(2, 8);
            for (int n = 0; n < 250; n++)
            begin
                if (ph == 4 && n == 125)
                    drain();
                random_gap();
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_page(base + PAGE_BITS'($urandom_range(0, pool - 1)));
                else if (pick < 85)
                    send_page(last_page);
                else
                    send_page(PAGE_BITS'($urandom));
            end
        end

        drain();
        if (fail_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
